// ===== hw/rtl/timed_fire_sequencer_assert.svh =====
// Assertion macros shared by the sequencer RTL.
// Each use sits at the end of a module that has clk and arst_n.
`ifndef TIMED_FIRE_SEQUENCER_ASSERT_SVH
`define TIMED_FIRE_SEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TFS_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TFS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hw/rtl/tfs_pkg.sv =====
`timescale 1ns / 1ps

package tfs_pkg;

	localparam int CfgDataW = 16;
	localparam int CfgIdxW  = 3;
	localparam int LimitW   = 16;
	localparam int TolW     = 15;

	// Command codes
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_FIRE = 2'd1;
	localparam logic [1:0] CMD_STOP = 2'd2;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_ENABLE     = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SPINUP     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_FIRE       = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_COOLDOWN   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_CONF_THR   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_CENTER_TOL = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_SPEED      = 3'd6;

	// Register reset values
	localparam logic [LimitW-1:0] RST_SPINUP   = 16'd500;
	localparam logic [LimitW-1:0] RST_FIRE     = 16'd200;
	localparam logic [LimitW-1:0] RST_COOLDOWN = 16'd1000;
	localparam logic [15:0]       RST_CONF_THR = 16'd45875;
	localparam logic [TolW-1:0]   RST_TOL      = 15'd410;
	localparam logic [15:0]       RST_SPEED    = 16'd0;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [15:0]        confidence;
		logic signed [15:0] pan_offset;
		logic signed [15:0] tilt_offset;
	} tfs_in_t;

	typedef struct packed {
		logic        fire_accepted;
		logic        trigger_pulse;
		logic        speed_write;
		logic [15:0] speed_value;
		logic [1:0]  phase;
	} tfs_out_t;

endpackage

// ===== hw/rtl/timed_fire_sequencer.sv =====
`timescale 1ns / 1ps
// Timed fire sequencer: idle -> spin-up -> firing -> cooldown -> idle.
// Input channel (in_valid / in_stall / in_data): one command per item, a
// 1 ms tick, a fire request with confidence and aim errors, or a stop.
// Output channel (out_valid / out_stall / out_data): exactly one result item
// per input item, in order, carrying the flags, speed command and new phase.
// Configuration: cfg_we with cfg_index and cfg_data writes one register;
// write only while no item is in flight.
// Path: an accepted item passes two registers, the input register and then
// the result register, where its result is shown with out_valid high.
// Throughput: one item per cycle unless the receiver stalls; phase and the
// ms counter update in the same cycle the item moves to the result register.
// Reset (arst_n low): phase idle, ms counter zero, registers at defaults,
// both valid flags cleared.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, after which in_stall rises until the result
// register drains.
module timed_fire_sequencer (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  tfs_pkg::tfs_in_t         in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output tfs_pkg::tfs_out_t        out_data,
	input  logic                     cfg_we,
	input  logic [tfs_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [tfs_pkg::CfgDataW-1:0] cfg_data
);
	import tfs_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_SPINUP   = 2'd1,
		PH_FIRING   = 2'd2,
		PH_COOLDOWN = 2'd3
	} phase_t;

	// Configuration registers
	logic              enable_q;
	logic [LimitW-1:0] spinup_limit_q;
	logic [LimitW-1:0] fire_limit_q;
	logic [LimitW-1:0] cooldown_limit_q;
	logic [15:0]       conf_thr_q;
	logic [TolW-1:0]   center_tol_q;
	logic [15:0]       speed_q;

	phase_t            phase_q, phase_d;
	logic [LimitW-1:0] elapsed_q, elapsed_d, elapsed_inc;

	logic     valid_s1;
	tfs_in_t  item_s1;
	logic     out_valid_q;
	tfs_out_t out_q;
	tfs_out_t res;

	logic     in_take, advance;
	logic [16:0] pan_abs, tilt_abs;
	logic        fire_ok;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q         <= 1'b0;
			spinup_limit_q   <= RST_SPINUP;
			fire_limit_q     <= RST_FIRE;
			cooldown_limit_q <= RST_COOLDOWN;
			conf_thr_q       <= RST_CONF_THR;
			center_tol_q     <= RST_TOL;
			speed_q          <= RST_SPEED;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:     enable_q         <= cfg_data[0];
				REG_SPINUP:     spinup_limit_q   <= cfg_data;
				REG_FIRE:       fire_limit_q     <= cfg_data;
				REG_COOLDOWN:   cooldown_limit_q <= cfg_data;
				REG_CONF_THR:   conf_thr_q       <= cfg_data;
				REG_CENTER_TOL: center_tol_q     <= cfg_data[TolW-1:0];
				REG_SPEED:      speed_q          <= cfg_data;
				default: ;
			endcase
		end
	end

	// Magnitudes are 17 bits so that the most negative error maps to 32768
	assign pan_abs  = item_s1.pan_offset[15]
		? 17'(-{item_s1.pan_offset[15], item_s1.pan_offset})
		: {1'b0, item_s1.pan_offset};
	assign tilt_abs = item_s1.tilt_offset[15]
		? 17'(-{item_s1.tilt_offset[15], item_s1.tilt_offset})
		: {1'b0, item_s1.tilt_offset};

	assign fire_ok = enable_q && (phase_q == PH_IDLE)
		&& (item_s1.confidence >= conf_thr_q)
		&& (pan_abs <= {2'b00, center_tol_q})
		&& (tilt_abs <= {2'b00, center_tol_q});

	assign elapsed_inc = (elapsed_q == {LimitW{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		phase_d           = phase_q;
		elapsed_d         = elapsed_q;
		res.fire_accepted = 1'b0;
		res.trigger_pulse = 1'b0;
		res.speed_write   = 1'b0;
		res.speed_value   = '0;
		unique case (item_s1.cmd)
			CMD_TICK: begin
				elapsed_d = elapsed_inc;
				if (enable_q) begin
					unique case (phase_q)
						PH_SPINUP: begin
							if (elapsed_inc >= spinup_limit_q) begin
								res.trigger_pulse = 1'b1;
								phase_d           = PH_FIRING;
								elapsed_d         = '0;
							end
						end
						PH_FIRING: begin
							if (elapsed_inc >= fire_limit_q) begin
								res.speed_write = 1'b1;
								phase_d         = PH_COOLDOWN;
								elapsed_d       = '0;
							end
						end
						PH_COOLDOWN: begin
							// keep the counter on the way back to idle
							if (elapsed_inc >= cooldown_limit_q) begin
								phase_d = PH_IDLE;
							end
						end
						default: ;
					endcase
				end
			end
			CMD_FIRE: begin
				if (fire_ok) begin
					res.fire_accepted = 1'b1;
					res.speed_write   = 1'b1;
					res.speed_value   = speed_q;
					phase_d           = PH_SPINUP;
					elapsed_d         = '0;
				end
			end
			CMD_STOP: begin
				res.speed_write = (phase_q != PH_IDLE);
				phase_d         = PH_IDLE;
			end
			default: ;
		endcase
		res.phase = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			elapsed_q   <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				phase_q     <= phase_d;
				elapsed_q   <= elapsed_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_q <= res;
		end
	end

`include "timed_fire_sequencer_assert.svh"

	`TFS_ASSERT_NEXT(a_trig_enters_firing, advance && res.trigger_pulse,
		phase_q == PH_FIRING && elapsed_q == '0, "trigger without entering firing")
	`TFS_ASSERT_NEXT(a_accept_enters_spinup, advance && res.fire_accepted,
		phase_q == PH_SPINUP && elapsed_q == '0, "accepted fire without spin-up")
	`TFS_ASSERT_NEXT(a_state_holds_idle, !advance,
		$stable(phase_q) && $stable(elapsed_q), "state moved with no item")
	`TFS_ASSERT_NOW(a_stall_only_when_held, in_stall,
		valid_s1 && out_valid_q && out_stall, "input stalled with room")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import tfs_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_SPINUP   = 2'd1;
	localparam logic [1:0] PH_FIRING   = 2'd2;
	localparam logic [1:0] PH_COOLDOWN = 2'd3;

	localparam int CYCLE_LIMIT = 200_000;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_TOGGLE, STALL_HEAVY} stall_mode_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	tfs_in_t             in_data;
	logic                out_valid;
	logic                out_stall;
	tfs_out_t            out_data;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	// Predicted sequencer state and register copy
	logic        cfg_en;
	logic [15:0] cfg_spin;
	logic [15:0] cfg_fire;
	logic [15:0] cfg_cool;
	logic [15:0] cfg_thr;
	logic [14:0] cfg_tol;
	logic [15:0] cfg_speed;
	logic [1:0]  seq_phase;
	logic [15:0] seq_ms;

	tfs_out_t    results_due[$];
	tfs_out_t    head_result;
	int          mismatches;
	int          cycle_count;
	int          burst_left;
	bit          gaps_on;
	int          hold_left;
	int          mode_left;
	stall_mode_t stall_mode;

	timed_fire_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: long hold-off when requested, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				STALL_NONE:   out_stall <= 1'b0;
				STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
				STALL_TOGGLE: out_stall <= ~out_stall;
				default:      out_stall <= ($urandom_range(0, 9) < 6);
			endcase
		end
	end

	function automatic tfs_out_t advance_sequencer(input tfs_in_t it);
		tfs_out_t r;
		int       pan_mag;
		int       tilt_mag;
		r = '0;
		pan_mag = it.pan_offset;
		tilt_mag = it.tilt_offset;
		if (pan_mag < 0) pan_mag = -pan_mag;
		if (tilt_mag < 0) tilt_mag = -tilt_mag;
		case (it.cmd)
			CMD_TICK: begin
				if (seq_ms != 16'hFFFF) seq_ms++;
				if (cfg_en) begin
					case (seq_phase)
						PH_SPINUP: begin
							if (seq_ms >= cfg_spin) begin
								r.trigger_pulse = 1'b1;
								seq_phase = PH_FIRING;
								seq_ms = '0;
							end
						end
						PH_FIRING: begin
							if (seq_ms >= cfg_fire) begin
								r.speed_write = 1'b1;
								seq_phase = PH_COOLDOWN;
								seq_ms = '0;
							end
						end
						PH_COOLDOWN: begin
							// elapsed time is kept on the way back to idle
							if (seq_ms >= cfg_cool) seq_phase = PH_IDLE;
						end
						default: ;
					endcase
				end
			end
			CMD_FIRE: begin
				if (cfg_en && seq_phase == PH_IDLE && it.confidence >= cfg_thr &&
						pan_mag <= int'(cfg_tol) && tilt_mag <= int'(cfg_tol)) begin
					r.fire_accepted = 1'b1;
					r.speed_write = 1'b1;
					r.speed_value = cfg_speed;
					seq_phase = PH_SPINUP;
					seq_ms = '0;
				end
			end
			CMD_STOP: begin
				if (seq_phase != PH_IDLE) r.speed_write = 1'b1;
				seq_phase = PH_IDLE;
			end
			default: ;
		endcase
		r.phase = seq_phase;
		return r;
	endfunction

	function automatic tfs_in_t rand_fields(input logic [1:0] cmd);
		tfs_in_t it;
		it.cmd = cmd;
		it.confidence = 16'($urandom);
		it.pan_offset = 16'($urandom);
		it.tilt_offset = 16'($urandom);
		return it;
	endfunction

	function automatic tfs_in_t fire_item(input logic [15:0] conf, input logic [15:0] pan,
			input logic [15:0] tilt);
		tfs_in_t it;
		it.cmd = CMD_FIRE;
		it.confidence = conf;
		it.pan_offset = pan;
		it.tilt_offset = tilt;
		return it;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result item, expected none, actual %0h", $time,
					out_data);
				mismatches++;
			end else begin
				head_result = results_due.pop_front();
				check_field("fire_accepted", head_result.fire_accepted, out_data.fire_accepted);
				check_field("trigger_pulse", head_result.trigger_pulse, out_data.trigger_pulse);
				check_field("speed_write", head_result.speed_write, out_data.speed_write);
				check_field("speed_value", head_result.speed_value, out_data.speed_value);
				check_field("phase", head_result.phase, out_data.phase);
			end
		end
	end

	// Offer one item in bursts; hold it until taken, then predict its result
	task automatic send_item(input tfs_in_t it);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0) burst_left--;
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		results_due.push_back(advance_sequencer(it));
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_item(rand_fields(CMD_TICK));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write only the registers whose value changes, with nothing in flight
	task automatic program_regs(input logic en, input logic [15:0] spin, input logic [15:0] fire,
			input logic [15:0] cool, input logic [15:0] thr, input logic [14:0] tol,
			input logic [15:0] spd);
		logic [15:0]        want [7];
		logic [15:0]        have [7];
		logic [CfgIdxW-1:0] ids [7];
		bit                 wrote;
		want = '{{15'd0, en}, spin, fire, cool, thr, {1'b0, tol}, spd};
		have = '{{15'd0, cfg_en}, cfg_spin, cfg_fire, cfg_cool, cfg_thr, {1'b0, cfg_tol},
			cfg_speed};
		ids = '{REG_ENABLE, REG_SPINUP, REG_FIRE, REG_COOLDOWN, REG_CONF_THR, REG_CENTER_TOL,
			REG_SPEED};
		wrote = 1'b0;
		drain_results();
		for (int i = 0; i < 7; i++) begin
			if (want[i] != have[i]) begin
				cfg_we <= 1'b1;
				cfg_index <= ids[i];
				cfg_data <= want[i];
				@(posedge clk);
				wrote = 1'b1;
			end
		end
		if (wrote) cfg_we <= 1'b0;
		cfg_en = en;
		cfg_spin = spin;
		cfg_fire = fire;
		cfg_cool = cool;
		cfg_thr = thr;
		cfg_tol = tol;
		cfg_speed = spd;
	endtask

	task automatic test_reset_values();
		send_item(fire_item(16'hFFFF, 16'h0000, 16'h0000));
		send_item(rand_fields(CMD_TICK));
		send_item(rand_fields(CMD_STOP));
		send_item(rand_fields(CMD_UNUSED));
		program_regs(1'b1, RST_SPINUP, RST_FIRE, RST_COOLDOWN, RST_CONF_THR, RST_TOL, RST_SPEED);
		send_item(fire_item(RST_CONF_THR - 16'd1, 16'h0000, 16'h0000));
		send_item(fire_item(RST_CONF_THR, 16'(RST_TOL), -16'(RST_TOL)));
		send_item(fire_item(16'hFFFF, 16'h0000, 16'h0000));
		// walk the default spin-up and firing times, then part of cooldown
		send_ticks(int'(RST_SPINUP));
		send_ticks(int'(RST_FIRE));
		send_ticks(50);
		send_item(rand_fields(CMD_STOP));
	endtask

	task automatic test_directed();
		program_regs(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 15'h7FFF, 16'hFFFF);
		send_item(fire_item(16'h0000, 16'h7FFF, 16'h8001));
		send_ticks(3);
		send_item(fire_item(16'hFFFF, 16'h8000, 16'h0000));
		send_item(fire_item(16'hFFFF, 16'h0000, 16'h8000));
		send_item(fire_item(16'h0000, 16'h0000, 16'h0000));
		send_item(rand_fields(CMD_STOP));
		send_item(rand_fields(CMD_STOP));
		program_regs(1'b1, 16'd3, 16'd2, 16'd1, 16'hFFFF, 15'd0, 16'h1234);
		send_item(fire_item(16'hFFFE, 16'h0000, 16'h0000));
		send_item(fire_item(16'hFFFF, 16'h0001, 16'h0000));
		send_item(fire_item(16'hFFFF, 16'h0000, 16'hFFFF));
		send_item(fire_item(16'hFFFF, 16'h0000, 16'h0000));
		send_ticks(4);
		send_item(rand_fields(CMD_STOP));
		send_item(fire_item(16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_item(rand_fields(CMD_UNUSED));
	endtask

	task automatic test_output_holdoff();
		program_regs(1'b1, 16'd1, 16'd1, 16'd1, 16'd0, 15'h7FFF, 16'h5A5A);
		gaps_on = 1'b0;
		hold_left = 300;
		repeat (60) begin
			if ($urandom_range(0, 2) == 0)
				send_item(fire_item(16'($urandom), 16'h0000, 16'h0000));
			else
				send_item(rand_fields(CMD_TICK));
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_random_phases();
		tfs_in_t it;
		int      roll;
		for (int p = 0; p < 12; p++) begin
			case (p)
				0: program_regs(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 15'h7FFF, 16'hFFFF);
				1: program_regs(1'b1, 16'd1, 16'd1, 16'd1, 16'hFFFF, 15'd0, 16'd0);
				2: program_regs(1'b0, 16'd2, 16'd1, 16'd2, 16'($urandom), 15'($urandom),
					16'($urandom));
				3: program_regs(1'b1, 16'hFFFF, 16'hFFFF, 16'd2, 16'($urandom_range(0, 40000)),
					15'($urandom), 16'($urandom));
				default: program_regs(1'b1, 16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
					16'($urandom_range(0, 6)), 16'($urandom), 15'($urandom), 16'($urandom));
			endcase
			gaps_on = (p != 5);
			repeat (85) begin
				roll = $urandom_range(0, 99);
				it = rand_fields(CMD_TICK);
				if (roll >= 52 && roll < 89) begin
					it.cmd = CMD_FIRE;
					// well-formed request inside the current window
					it.confidence = 16'(int'(cfg_thr) + $urandom_range(0, 65535 - cfg_thr));
					it.pan_offset = 16'($urandom_range(0, 2 * cfg_tol) - int'(cfg_tol));
					it.tilt_offset = 16'($urandom_range(0, 2 * cfg_tol) - int'(cfg_tol));
					if (roll >= 77 && roll < 84) begin
						it = rand_fields(CMD_FIRE);
					end else if (roll >= 84) begin
						// miss by one on a single field
						case ($urandom_range(0, 2))
							0: it.confidence = cfg_thr - 16'd1;
							1: it.pan_offset = (cfg_tol == 15'h7FFF) ? 16'h8000 :
								($urandom_range(0, 1) ? 16'(cfg_tol + 1) : -16'(cfg_tol + 1));
							default: it.tilt_offset = (cfg_tol == 15'h7FFF) ? 16'h8000 :
								($urandom_range(0, 1) ? 16'(cfg_tol + 1) : -16'(cfg_tol + 1));
						endcase
					end
				end else if (roll >= 89 && roll < 96) begin
					it.cmd = CMD_STOP;
				end else if (roll >= 96) begin
					it.cmd = CMD_UNUSED;
				end
				send_item(it);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_stall <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ENABLE;
		cfg_data <= '0;
		cfg_en = 1'b0;
		cfg_spin = RST_SPINUP;
		cfg_fire = RST_FIRE;
		cfg_cool = RST_COOLDOWN;
		cfg_thr = RST_CONF_THR;
		cfg_tol = RST_TOL;
		cfg_speed = RST_SPEED;
		seq_phase = PH_IDLE;
		seq_ms = '0;
		mismatches = 0;
		cycle_count = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		hold_left = 0;
		mode_left = 0;
		stall_mode = STALL_NONE;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed();
		test_output_holdoff();
		test_random_phases();
		drain_results();
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
